@@ rtl/clcd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package clcd_pkg;

    typedef enum logic [2:0]
    {
        PH_WAIT1,
        PH_WAIT2,
        PH_WAIT3,
        PH_POLL_START,
        PH_POLL_WAIT,
        PH_DATA_READ,
        PH_IDLE
    } phase_t;

    typedef enum logic [1:0]
    {
        KIND_INIT,
        KIND_CMD,
        KIND_WDATA,
        KIND_RDATA
    } kind_t;

    typedef enum logic [1:0]
    {
        EV_TICK,
        EV_RETURN,
        EV_REQUEST,
        EV_NONE
    } event_t;

    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_RETURN = 3'd1;
    localparam logic [2:0] MODE_WCMD   = 3'd2;
    localparam logic [2:0] MODE_WDATA  = 3'd3;
    localparam logic [2:0] MODE_RDATA  = 3'd4;

    localparam logic [1:0] BUS_NONE  = 2'd0;
    localparam logic [1:0] BUS_WRITE = 2'd1;
    localparam logic [1:0] BUS_READ  = 2'd2;

    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;
    localparam logic [1:0] ST_REJECT  = 2'd3;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_BUSY_TIMEOUT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_POWER_UP     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SECOND_WAIT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_THIRD_WAIT   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FUNCTION_SET = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DISPLAY_CTRL = 3'd5;

    localparam logic [15:0] RST_BUSY_TIMEOUT = 16'd1001;
    localparam logic [15:0] RST_POWER_UP     = 16'd1501;
    localparam logic [15:0] RST_SECOND_WAIT  = 16'd411;
    localparam logic [15:0] RST_THIRD_WAIT   = 16'd11;
    localparam logic [7:0]  RST_FUNCTION_SET = 8'h3A;
    localparam logic [7:0]  RST_DISPLAY_CTRL = 8'h0E;

    localparam logic [2:0] INIT_COUNT = 3'd6;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed
    {
        event_t     ev;
        kind_t      kind;
        logic [7:0] data;
    } item_t;

    typedef struct packed
    {
        logic [1:0] bus_op;
        logic       reg_select;
        logic [7:0] bus_byte;
        logic [1:0] status;
        logic [7:0] read_byte;
        logic       ready_res;
    } result_t;

    function automatic logic [7:0] init_command(
        input logic [2:0] step,
        input logic [7:0] fs_word,
        input logic [7:0] dc_word
    );
        logic [7:0] cmd;
        case (step)
            3'd0:    cmd = fs_word;
            3'd1:    cmd = 8'h08;
            3'd2:    cmd = 8'h01;
            3'd3:    cmd = 8'h02;
            3'd4:    cmd = 8'h06;
            default: cmd = dc_word;
        endcase
        return cmd;
    endfunction

endpackage

`default_nettype wire

@@ rtl/char_lcd_busy_poll_controller.sv @@
// An accepted transfer is written into the queue, then into the result register when popped.
// Throughput: one item per cycle while rsp_stall is low; the two-entry queue absorbs a stalled result.
// req_stall is high only while the queue is full.
// Reset (rst_n, async, active low) restores register defaults and enters the
// first power-up wait; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_busy_poll_controller
#(
    parameter int TICK_WIDTH         = 16,
    parameter int READY_READS_NEEDED = 2
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [clcd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [clcd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             req_valid,
    output logic                                  req_stall,
    input  wire logic [2:0]                       mode,
    input  wire logic [7:0]                       host_byte,
    input  wire logic [7:0]                       lcd_byte,
    output logic                                  rsp_valid,
    input  wire logic                             rsp_stall,
    output logic [1:0]                            bus_op,
    output logic                                  reg_select,
    output logic [7:0]                            bus_byte,
    output logic [1:0]                            status,
    output logic [7:0]                            read_byte,
    output logic                                  ready_res
);

    clcd_pkg::item_t   front_item;
    clcd_pkg::item_t   head_item;
    clcd_pkg::result_t result;
    logic              q_full;
    logic              q_not_empty;
    logic              q_pop;

    assign req_stall = q_full;

    clcd_front u_front
    (
        .mode      (mode),
        .host_byte (host_byte),
        .lcd_byte  (lcd_byte),
        .item      (front_item)
    );

    clcd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (req_valid && !q_full),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    clcd_back
    #(
        .TICK_WIDTH         (TICK_WIDTH),
        .READY_READS_NEEDED (READY_READS_NEEDED)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (q_not_empty),
        .item       (head_item),
        .item_pop   (q_pop),
        .res_stall  (rsp_stall),
        .res_valid  (rsp_valid),
        .result     (result)
    );

    assign bus_op     = result.bus_op;
    assign reg_select = result.reg_select;
    assign bus_byte   = result.bus_byte;
    assign status     = result.status;
    assign read_byte  = result.read_byte;
    assign ready_res  = result.ready_res;

endmodule

`default_nettype wire

@@ rtl/clcd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module clcd_front
(
    input  wire logic [2:0]      mode,
    input  wire logic [7:0]      host_byte,
    input  wire logic [7:0]      lcd_byte,
    output clcd_pkg::item_t      item
);

    always_comb
    begin
        item.ev   = clcd_pkg::EV_NONE;
        item.kind = clcd_pkg::KIND_CMD;
        item.data = 8'd0;
        case (mode)
            clcd_pkg::MODE_TICK:
            begin
                item.ev = clcd_pkg::EV_TICK;
            end
            clcd_pkg::MODE_RETURN:
            begin
                item.ev   = clcd_pkg::EV_RETURN;
                item.data = lcd_byte;
            end
            clcd_pkg::MODE_WCMD:
            begin
                item.ev   = clcd_pkg::EV_REQUEST;
                item.kind = clcd_pkg::KIND_CMD;
                item.data = host_byte;
            end
            clcd_pkg::MODE_WDATA:
            begin
                item.ev   = clcd_pkg::EV_REQUEST;
                item.kind = clcd_pkg::KIND_WDATA;
                item.data = host_byte;
            end
            clcd_pkg::MODE_RDATA:
            begin
                item.ev   = clcd_pkg::EV_REQUEST;
                item.kind = clcd_pkg::KIND_RDATA;
            end
            default:
            begin
                item.ev = clcd_pkg::EV_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/clcd_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module clcd_queue
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire clcd_pkg::item_t   push_item,
    output logic                   full,
    input  wire logic              pop,
    output logic                   not_empty,
    output clcd_pkg::item_t        head_item
);

    localparam int PTR_W = (clcd_pkg::QUEUE_DEPTH > 1) ? $clog2(clcd_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(clcd_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(clcd_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(clcd_pkg::QUEUE_DEPTH - 1);

    clcd_pkg::item_t entry_reg [clcd_pkg::QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == DEPTH_CNT);
    assign not_empty = (count_reg != '0);
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/clcd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module clcd_back
#(
    parameter int TICK_WIDTH         = 16,
    parameter int READY_READS_NEEDED = 2
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [clcd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [clcd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                item_valid,
    input  wire clcd_pkg::item_t                     item,
    output logic                                     item_pop,
    input  wire logic                                res_stall,
    output logic                                     res_valid,
    output clcd_pkg::result_t                        result
);

    localparam int CMP_W = (TICK_WIDTH > 16) ? TICK_WIDTH : 16;
    localparam logic [1:0] READY_NEEDED = 2'(READY_READS_NEEDED);

    logic [15:0] timeout_reg;
    logic [15:0] power_up_reg;
    logic [15:0] second_wait_reg;
    logic [15:0] third_wait_reg;
    logic [7:0]  fs_word_reg;
    logic [7:0]  dc_word_reg;

    clcd_pkg::phase_t      phase_reg, phase_next;
    logic [TICK_WIDTH-1:0] elapsed_reg, elapsed_next;
    logic [1:0]            ready_reads_reg, ready_reads_next;
    logic                  recheck_reg, recheck_next;
    clcd_pkg::kind_t       kind_reg, kind_next;
    logic [7:0]            pend_byte_reg, pend_byte_next;
    logic [2:0]            init_step_reg, init_step_next;

    clcd_pkg::result_t     res_reg, res_next;
    logic                  res_valid_reg;

    logic [TICK_WIDTH-1:0] elapsed_sat;
    logic [15:0]           wait_limit;
    logic                  wait_hit;
    logic [1:0]            ready_inc;
    logic                  poll_ok;
    logic                  timed_out;
    logic                  lcd_busy;
    logic [2:0]            step_inc;

    assign item_pop  = item_valid && (!res_valid_reg || !res_stall);
    assign res_valid = res_valid_reg;
    assign result    = res_reg;

    // shared decode for both next-state and result logic
    assign elapsed_sat = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;

    always_comb
    begin
        case (phase_reg)
            clcd_pkg::PH_WAIT1: wait_limit = power_up_reg;
            clcd_pkg::PH_WAIT2: wait_limit = second_wait_reg;
            default:            wait_limit = third_wait_reg;
        endcase
    end

    assign wait_hit  = CMP_W'(elapsed_sat) >= CMP_W'(wait_limit);
    assign ready_inc = ready_reads_reg + 2'd1;
    assign poll_ok   = ready_inc >= READY_NEEDED;
    assign timed_out = CMP_W'(elapsed_reg) >= CMP_W'(timeout_reg);
    assign lcd_busy  = item.data[7];
    assign step_inc  = init_step_reg + 3'd1;

    always_comb
    begin
        phase_next       = phase_reg;
        elapsed_next     = elapsed_reg;
        ready_reads_next = ready_reads_reg;
        recheck_next     = recheck_reg;
        kind_next        = kind_reg;
        pend_byte_next   = pend_byte_reg;
        init_step_next   = init_step_reg;
        if (item_pop)
        begin
            case (item.ev)
                clcd_pkg::EV_TICK:
                begin
                    case (phase_reg)
                        clcd_pkg::PH_WAIT1, clcd_pkg::PH_WAIT2, clcd_pkg::PH_WAIT3:
                        begin
                            elapsed_next = elapsed_sat;
                            if (wait_hit)
                            begin
                                elapsed_next = '0;
                                case (phase_reg)
                                    clcd_pkg::PH_WAIT1: phase_next = clcd_pkg::PH_WAIT2;
                                    clcd_pkg::PH_WAIT2: phase_next = clcd_pkg::PH_WAIT3;
                                    default:
                                    begin
                                        phase_next     = clcd_pkg::PH_POLL_START;
                                        kind_next      = clcd_pkg::KIND_INIT;
                                        init_step_next = '0;
                                    end
                                endcase
                            end
                        end
                        clcd_pkg::PH_POLL_START:
                        begin
                            elapsed_next     = '0;
                            ready_reads_next = '0;
                            recheck_next     = 1'b0;
                            phase_next       = clcd_pkg::PH_POLL_WAIT;
                        end
                        clcd_pkg::PH_POLL_WAIT:
                        begin
                            elapsed_next = elapsed_sat;
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
                clcd_pkg::EV_RETURN:
                begin
                    case (phase_reg)
                        clcd_pkg::PH_POLL_WAIT:
                        begin
                            if (!lcd_busy)
                            begin
                                recheck_next     = 1'b0;
                                ready_reads_next = ready_inc;
                                if (poll_ok)
                                begin
                                    ready_reads_next = '0;
                                    case (kind_reg)
                                        clcd_pkg::KIND_INIT:
                                        begin
                                            init_step_next = step_inc;
                                            phase_next = (step_inc >= clcd_pkg::INIT_COUNT) ?
                                                         clcd_pkg::PH_IDLE :
                                                         clcd_pkg::PH_POLL_START;
                                        end
                                        clcd_pkg::KIND_RDATA:
                                        begin
                                            phase_next = clcd_pkg::PH_DATA_READ;
                                        end
                                        default:
                                        begin
                                            phase_next = clcd_pkg::PH_IDLE;
                                        end
                                    endcase
                                end
                            end
                            else if (recheck_reg)
                            begin
                                recheck_next     = 1'b0;
                                ready_reads_next = '0;
                                phase_next       = clcd_pkg::PH_IDLE;
                            end
                            else if (timed_out)
                            begin
                                recheck_next = 1'b1;
                            end
                            else
                            begin
                                ready_reads_next = '0;
                            end
                        end
                        clcd_pkg::PH_DATA_READ:
                        begin
                            phase_next = clcd_pkg::PH_IDLE;
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
                clcd_pkg::EV_REQUEST:
                begin
                    if (phase_reg == clcd_pkg::PH_IDLE)
                    begin
                        kind_next        = item.kind;
                        pend_byte_next   = item.data;
                        elapsed_next     = '0;
                        ready_reads_next = '0;
                        recheck_next     = 1'b0;
                        phase_next       = clcd_pkg::PH_POLL_WAIT;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        res_next            = '0;
        res_next.ready_res  = (phase_next == clcd_pkg::PH_IDLE);
        case (item.ev)
            clcd_pkg::EV_TICK:
            begin
                case (phase_reg)
                    clcd_pkg::PH_WAIT1, clcd_pkg::PH_WAIT2, clcd_pkg::PH_WAIT3:
                    begin
                        if (wait_hit)
                        begin
                            res_next.bus_op   = clcd_pkg::BUS_WRITE;
                            res_next.bus_byte = fs_word_reg;
                        end
                    end
                    clcd_pkg::PH_POLL_START:
                    begin
                        res_next.bus_op = clcd_pkg::BUS_READ;
                    end
                    default:
                    begin
                        res_next.bus_op = clcd_pkg::BUS_NONE;
                    end
                endcase
            end
            clcd_pkg::EV_RETURN:
            begin
                case (phase_reg)
                    clcd_pkg::PH_POLL_WAIT:
                    begin
                        if (!lcd_busy && poll_ok)
                        begin
                            case (kind_reg)
                                clcd_pkg::KIND_INIT:
                                begin
                                    res_next.bus_op   = clcd_pkg::BUS_WRITE;
                                    res_next.bus_byte = clcd_pkg::init_command(init_step_reg,
                                                            fs_word_reg, dc_word_reg);
                                end
                                clcd_pkg::KIND_CMD:
                                begin
                                    res_next.bus_op   = clcd_pkg::BUS_WRITE;
                                    res_next.bus_byte = pend_byte_reg;
                                    res_next.status   = clcd_pkg::ST_DONE;
                                end
                                clcd_pkg::KIND_WDATA:
                                begin
                                    res_next.bus_op     = clcd_pkg::BUS_WRITE;
                                    res_next.reg_select = 1'b1;
                                    res_next.bus_byte   = pend_byte_reg;
                                    res_next.status     = clcd_pkg::ST_DONE;
                                end
                                default:
                                begin
                                    res_next.bus_op     = clcd_pkg::BUS_READ;
                                    res_next.reg_select = 1'b1;
                                end
                            endcase
                        end
                        else if (lcd_busy && recheck_reg)
                        begin
                            res_next.status = clcd_pkg::ST_TIMEOUT;
                        end
                        else
                        begin
                            res_next.bus_op = clcd_pkg::BUS_READ;
                        end
                    end
                    clcd_pkg::PH_DATA_READ:
                    begin
                        res_next.status    = clcd_pkg::ST_DONE;
                        res_next.read_byte = item.data;
                    end
                    default:
                    begin
                        res_next.bus_op = clcd_pkg::BUS_NONE;
                    end
                endcase
            end
            clcd_pkg::EV_REQUEST:
            begin
                if (phase_reg == clcd_pkg::PH_IDLE)
                begin
                    res_next.bus_op = clcd_pkg::BUS_READ;
                end
                else
                begin
                    res_next.status = clcd_pkg::ST_REJECT;
                end
            end
            default:
            begin
                res_next.bus_op = clcd_pkg::BUS_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= clcd_pkg::RST_BUSY_TIMEOUT;
            power_up_reg    <= clcd_pkg::RST_POWER_UP;
            second_wait_reg <= clcd_pkg::RST_SECOND_WAIT;
            third_wait_reg  <= clcd_pkg::RST_THIRD_WAIT;
            fs_word_reg     <= clcd_pkg::RST_FUNCTION_SET;
            dc_word_reg     <= clcd_pkg::RST_DISPLAY_CTRL;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                clcd_pkg::REG_BUSY_TIMEOUT: timeout_reg     <= cfg_data;
                clcd_pkg::REG_POWER_UP:     power_up_reg    <= cfg_data;
                clcd_pkg::REG_SECOND_WAIT:  second_wait_reg <= cfg_data;
                clcd_pkg::REG_THIRD_WAIT:   third_wait_reg  <= cfg_data;
                clcd_pkg::REG_FUNCTION_SET: fs_word_reg     <= cfg_data[7:0];
                clcd_pkg::REG_DISPLAY_CTRL: dc_word_reg     <= cfg_data[7:0];
                default:                    fs_word_reg     <= fs_word_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= clcd_pkg::PH_WAIT1;
            elapsed_reg     <= '0;
            ready_reads_reg <= '0;
            recheck_reg     <= 1'b0;
            kind_reg        <= clcd_pkg::KIND_INIT;
            pend_byte_reg   <= '0;
            init_step_reg   <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            elapsed_reg     <= elapsed_next;
            ready_reads_reg <= ready_reads_next;
            recheck_reg     <= recheck_next;
            kind_reg        <= kind_next;
            pend_byte_reg   <= pend_byte_next;
            init_step_reg   <= init_step_next;
            if (item_pop)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/clcd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module clcd_checker
(
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             req_valid,
    input wire logic                             req_stall,
    input wire logic                             rsp_valid,
    input wire logic                             rsp_stall,
    input wire logic [1:0]                       bus_op,
    input wire logic [7:0]                       bus_byte,
    input wire logic [1:0]                       status,
    input wire logic [7:0]                       read_byte,
    input wire logic                             ready_res
);

    // a held result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result dropped while stalled");

    // a fresh result follows an earlier input transfer
    a_rsp_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
        else $error("result without input transfer");

    a_idle_bus: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && bus_op != clcd_pkg::BUS_WRITE |-> bus_byte == 8'd0)
        else $error("bus byte driven without a write");

    a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && read_byte != 8'd0 |->
            status == clcd_pkg::ST_DONE && bus_op == clcd_pkg::BUS_NONE && ready_res)
        else $error("read byte outside a completed read");

    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == clcd_pkg::ST_REJECT |->
            bus_op == clcd_pkg::BUS_NONE && !ready_res)
        else $error("rejected request caused bus activity");

endmodule

bind char_lcd_busy_poll_controller clcd_checker u_clcd_checker (.*);

`default_nettype wire
